// File: rtl/cwt_pkg.sv
// ----------------------------------------------------------------------------
// cwt_pkg
// Shared types, codes and the microcode program of the card id table.
// ----------------------------------------------------------------------------
package cwt_pkg;

  localparam int UID_W    = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W_O = 6;
  localparam int FREE_W_O = 7;
  localparam int STEP_W   = 3;

  // Operations
  localparam logic [OP_W-1:0] OP_SCAN_ALL    = 2'd0;
  localparam logic [OP_W-1:0] OP_SCAN_MASTER = 2'd1;
  localparam logic [OP_W-1:0] OP_ADD         = 2'd2;
  localparam logic [OP_W-1:0] OP_REMOVE      = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_MATCH     = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOMATCH   = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_ADDED     = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 3'd5;
  localparam logic [STATUS_W-1:0] STATUS_NOTFOUND  = 3'd6;

  // Configuration register indexes
  localparam logic CFG_MASTER_UID = 1'b0;
  localparam logic CFG_MASTER_EN  = 1'b1;

  // Program steps
  localparam logic [STEP_W-1:0] STEP_CLEAR  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_PRIME  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_WALK   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_DECIDE = 3'd4;

  typedef enum logic [1:0] {
    AD_HOLD,
    AD_ZERO,
    AD_INC
  } addr_op_t;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_GOTO,
    JC_ADDR_LAST,
    JC_ACCEPT,
    JC_CMP_LAST,
    JC_OUT_FREE
  } jcond_t;

  typedef struct packed {
    logic              take_item;
    logic              clear_wr;
    logic              cmp_en;
    logic              commit;
    addr_op_t          addr_op;
    jcond_t            jc;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic accept;
    logic addr_last;
    logic cmp_last;
    logic out_free;
  } seq_cond_t;

  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] pc);
    uword_t w;
    w = '{take_item: 1'b0, clear_wr: 1'b0, cmp_en: 1'b0, commit: 1'b0,
          addr_op: AD_HOLD, jc: JC_GOTO, target: STEP_IDLE};
    case (pc)
      STEP_CLEAR: begin
        w.clear_wr = 1'b1;
        w.addr_op  = AD_INC;
        w.jc       = JC_ADDR_LAST;
        w.target   = STEP_IDLE;
      end
      STEP_IDLE: begin
        w.take_item = 1'b1;
        w.addr_op   = AD_ZERO;
        w.jc        = JC_ACCEPT;
        w.target    = STEP_PRIME;
      end
      STEP_PRIME: begin
        w.addr_op = AD_INC;
        w.jc      = JC_NEXT;
      end
      STEP_WALK: begin
        w.cmp_en  = 1'b1;
        w.addr_op = AD_INC;
        w.jc      = JC_CMP_LAST;
        w.target  = STEP_DECIDE;
      end
      STEP_DECIDE: begin
        w.commit = 1'b1;
        w.jc     = JC_OUT_FREE;
        w.target = STEP_IDLE;
      end
      default: begin
        w.jc     = JC_GOTO;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/cwt_seq.sv
// ----------------------------------------------------------------------------
// cwt_seq
// Step counter and microcode table; issues one control word per cycle.
// ----------------------------------------------------------------------------
module cwt_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  cwt_pkg::seq_cond_t cond,
  output cwt_pkg::uword_t    ctl
);
  import cwt_pkg::*;

  logic [STEP_W-1:0] pc_r;
  logic [STEP_W-1:0] pc_nxt;

  assign ctl = ucode_rom(pc_r);

  always_comb begin
    pc_nxt = pc_r;
    case (ctl.jc)
      JC_NEXT:      pc_nxt = pc_r + STEP_W'(1);
      JC_GOTO:      pc_nxt = ctl.target;
      JC_ADDR_LAST: if (cond.addr_last) pc_nxt = ctl.target;
      JC_ACCEPT:    if (cond.accept)    pc_nxt = ctl.target;
      JC_CMP_LAST:  if (cond.cmp_last)  pc_nxt = ctl.target;
      JC_OUT_FREE:  if (cond.out_free)  pc_nxt = ctl.target;
      default:      pc_nxt = STEP_IDLE;
    endcase
  end

  // Restart with the table clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_CLEAR;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// File: rtl/card_id_whitelist_table_core.sv
// ----------------------------------------------------------------------------
// card_id_whitelist_table_core
// Card identifier access list: master slot from configuration, user slots in
// an on-chip table, driven by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, in_op, in_uid) carries one item: an
//   operation and a scanned identifier. Output channel (out_valid/out_stall)
//   returns exactly one result item per input item: status, slot index,
//   free-slot count and the master flag.
//   Each item walks every user slot once through the single table read port:
//   accept, a step to prime the read, one compare step per user slot and a
//   commit step. A new item is taken only after the previous one commits.
//   After reset a clearing pass marks every user slot empty; in_stall stays
//   high during it, while configuration writes are taken.
//   Results sit in an output register: the next item is accepted and walked
//   while a result is stalled, and the commit step holds until the output
//   register is free. Write master_uid and master_enabled only while idle.
// ----------------------------------------------------------------------------
module card_id_whitelist_table_core #(
  parameter int SLOTS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [cwt_pkg::UID_W-1:0]      cfg_wdata,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cwt_pkg::OP_W-1:0]       in_op,
  input  logic [cwt_pkg::UID_W-1:0]      in_uid,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cwt_pkg::STATUS_W-1:0]   out_status,
  output logic [cwt_pkg::SLOT_W_O-1:0]   out_slot_index,
  output logic [cwt_pkg::FREE_W_O-1:0]   out_free_slots,
  output logic                           out_master_present
);
  import cwt_pkg::*;

  localparam int USER_SLOTS = SLOTS - 1;
  localparam int ADDR_W     = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = SLOT_W;
  localparam int SLOT_EXT_W = (SLOT_W > SLOT_W_O) ? SLOT_W : SLOT_W_O;
  localparam int FREE_EXT_W = (CNT_W + 1 > FREE_W_O) ? CNT_W + 1 : FREE_W_O;
  localparam int ENTRY_W    = UID_W + 1;
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(USER_SLOTS - 1);

  // Sequencer
  uword_t    ctl;
  seq_cond_t cond;

  // Configuration
  logic [UID_W-1:0] master_uid_r;
  logic             master_en_r;

  // Item and walk state
  logic [OP_W-1:0]   op_r;
  logic [UID_W-1:0]  uid_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] addr_nxt;
  logic [ADDR_W-1:0] cmp_addr_r;
  logic              match_found_r;
  logic [ADDR_W-1:0] match_addr_r;
  logic              free_found_r;
  logic [ADDR_W-1:0] free_addr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;

  // Table: valid bit on top of the identifier
  logic [ENTRY_W-1:0] mem [USER_SLOTS];
  logic [ENTRY_W-1:0] rd_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [ENTRY_W-1:0] mem_wd;

  // Result
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [SLOT_W_O-1:0]   out_slot_index_r;
  logic [FREE_W_O-1:0]   out_free_slots_r;
  logic                  out_master_present_r;

  logic                  in_accept;
  logic                  out_free;
  logic                  commit_fire;
  logic                  master_hit;
  logic                  entry_hit;
  logic [STATUS_W-1:0]   status_c;
  logic [SLOT_W-1:0]     slot_c;
  logic                  do_add;
  logic                  do_remove;
  logic [SLOT_EXT_W-1:0] slot_ext;
  logic [FREE_EXT_W-1:0] free_ext;

  cwt_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .ctl   (ctl)
  );

  assign in_stall    = !ctl.take_item;
  assign in_accept   = in_valid && ctl.take_item;
  assign out_free    = !out_valid_r || !out_stall;
  assign commit_fire = ctl.commit && out_free;

  assign cond.accept    = in_accept;
  assign cond.addr_last = (addr_r == ADDR_LAST);
  assign cond.cmp_last  = (cmp_addr_r == ADDR_LAST);
  assign cond.out_free  = out_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_uid_r <= '0;
      master_en_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MASTER_UID: master_uid_r <= cfg_wdata;
        CFG_MASTER_EN:  master_en_r  <= cfg_wdata[0];
        default:        master_en_r  <= master_en_r;
      endcase
    end
  end

  // Address counter: saturate at the last slot so reads stay in range
  always_comb begin
    addr_nxt = addr_r;
    case (ctl.addr_op)
      AD_HOLD: addr_nxt = addr_r;
      AD_ZERO: addr_nxt = '0;
      AD_INC:  addr_nxt = cond.addr_last ? addr_r : addr_r + ADDR_W'(1);
      default: addr_nxt = addr_r;
    endcase
  end

  assign entry_hit = rd_q[UID_W] && (rd_q[UID_W-1:0] == uid_r);

  // Walk: read one slot per cycle; compare the slot read before it, from the registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r        <= '0;
      cmp_addr_r    <= '0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end else begin
      addr_r     <= addr_nxt;
      cmp_addr_r <= addr_r;
      if (in_accept) begin
        match_found_r <= 1'b0;
        free_found_r  <= 1'b0;
      end else if (ctl.cmp_en) begin
        // keep the lowest matching slot and the lowest free slot
        if (entry_hit && !match_found_r) begin
          match_found_r <= 1'b1;
        end
        if (!rd_q[UID_W] && !free_found_r) begin
          free_found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r  <= in_op;
      uid_r <= in_uid;
    end
    if (ctl.cmp_en && entry_hit && !match_found_r) begin
      match_addr_r <= cmp_addr_r;
    end
    if (ctl.cmp_en && !rd_q[UID_W] && !free_found_r) begin
      free_addr_r <= cmp_addr_r;
    end
  end

  // Decide the outcome once the walk is done
  assign master_hit = master_en_r && (master_uid_r == uid_r);

  always_comb begin
    status_c  = STATUS_NOMATCH;
    slot_c    = '0;
    do_add    = 1'b0;
    do_remove = 1'b0;
    case (op_r)
      OP_SCAN_ALL: begin
        if (master_hit) begin
          status_c = STATUS_MATCH;
        end else if (match_found_r) begin
          status_c = STATUS_MATCH;
          slot_c   = SLOT_W'(match_addr_r) + SLOT_W'(1);
        end
      end
      OP_SCAN_MASTER: begin
        if (master_uid_r == uid_r) begin
          status_c = STATUS_MATCH;
        end
      end
      OP_ADD: begin
        if (master_hit || match_found_r) begin
          status_c = STATUS_DUPLICATE;
        end else if (free_found_r) begin
          status_c = STATUS_ADDED;
          slot_c   = SLOT_W'(free_addr_r) + SLOT_W'(1);
          do_add   = 1'b1;
        end else begin
          status_c = STATUS_FULL;
        end
      end
      OP_REMOVE: begin
        if (match_found_r) begin
          status_c  = STATUS_REMOVED;
          slot_c    = SLOT_W'(match_addr_r) + SLOT_W'(1);
          do_remove = 1'b1;
        end else begin
          status_c = STATUS_NOTFOUND;
        end
      end
      default: status_c = STATUS_NOMATCH;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (commit_fire && do_add) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else if (commit_fire && do_remove) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  assign slot_ext = SLOT_EXT_W'(slot_c);
  assign free_ext = FREE_EXT_W'(cnt_nxt) + FREE_EXT_W'(!master_en_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_W'(USER_SLOTS);
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Table write port: clearing pass, add or remove
  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_wd = '0;
    if (ctl.clear_wr) begin
      mem_we = 1'b1;
    end else if (commit_fire && do_add) begin
      mem_we = 1'b1;
      mem_wa = free_addr_r;
      mem_wd = {1'b1, uid_r};
    end else if (commit_fire && do_remove) begin
      mem_we = 1'b1;
      mem_wa = match_addr_r;
      mem_wd = {1'b0, uid_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[addr_r];
  end

  // Output register: load on commit, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_fire) begin
      out_status_r         <= status_c;
      out_slot_index_r     <= slot_ext[SLOT_W_O-1:0];
      out_free_slots_r     <= free_ext[FREE_W_O-1:0];
      out_master_present_r <= master_en_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_slot_index     = out_slot_index_r;
  assign out_free_slots     = out_free_slots_r;
  assign out_master_present = out_master_present_r;

  // Free count never exceeds the number of user slots
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(USER_SLOTS))
    else $error("free user count out of range");

  // A committed add takes exactly one slot from the count
  a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
    commit_fire && do_add |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("add did not decrement free count");

  // Full is reported only when no user slot is free
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    commit_fire && (status_c == STATUS_FULL) |-> cnt_r == '0)
    else $error("full reported with free slots");

  // Outside the clearing pass the table changes only on a commit
  a_write_commit: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && !ctl.clear_wr |-> commit_fire && (do_add || do_remove))
    else $error("table written outside commit");

endmodule

// File: tb/sv/card_id_whitelist_table_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// card_id_whitelist_table_core_test
// Self-checking bench for the card id access list. A table of directed rows
// covers the corner cases. Random traffic follows in four idling phases: the
// stores are filled, drained and mixed with lookups. Every result is checked
// field by field, against a typed row result or a behavioural model run here.
// ----------------------------------------------------------------------------
module card_id_whitelist_table_core_test;
  import cwt_pkg::*;

  localparam int SLOTS          = 64;
  localparam int USER_SLOTS     = SLOTS - 1;
  localparam int RANDOM_ITEMS   = 1630;
  localparam int PHASES         = 4;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DIRECTED_ROWS  = 25;

  // One result item as the block reports it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W_O-1:0] slot;
    logic [FREE_W_O-1:0] free;
    logic                master;
  } verdict_t;

  // One directed row: either a register write or an item, optionally with
  // the result typed in by hand
  typedef struct packed {
    logic             is_cfg;
    logic             reg_sel;
    logic [OP_W-1:0]  op;
    logic [UID_W-1:0] value;
    logic             typed;
    verdict_t         want;
  } plan_row_t;

  // Operation mixes for the random traffic
  typedef enum int {
    FILL_ONLY,
    FILL_HEAVY,
    DRAIN_HEAVY,
    EVEN_MIX
  } mix_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = CFG_MASTER_UID;
  logic [UID_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_op = OP_SCAN_ALL;
  logic [UID_W-1:0]     in_uid = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [SLOT_W_O-1:0]  out_slot_index;
  logic [FREE_W_O-1:0]  out_free_slots;
  logic                 out_master_present;

  // Hand-typed expectation travelling alongside the item on the input port
  logic                 row_typed = 1'b0;
  verdict_t             row_want = '0;

  // Table model: master registers, user slots and the free counter
  logic [UID_W-1:0]     m_uid;
  logic                 m_en;
  logic [UID_W-1:0]     card_ids [USER_SLOTS];
  logic                 card_valid [USER_SLOTS];
  int                   free_cards;

  verdict_t             pending_verdicts [$];
  int                   mismatch_count = 0;
  int                   quiet_cycles = 0;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  int                   hold_asked = 0;
  int                   hold_taken = 0;
  int                   hold_left = 0;

  // Directed rows. After reset the master is disabled with identifier zero,
  // so every free count below is the user count plus one until enabled.
  plan_row_t directed_plan [DIRECTED_ROWS] = '{
    '{1'b0, 1'b0, OP_SCAN_ALL,    32'h0000_0000, 1'b1, '{STATUS_NOMATCH,   6'd0, 7'd64, 1'b0}},
    '{1'b0, 1'b0, OP_SCAN_MASTER, 32'h0000_0000, 1'b1, '{STATUS_MATCH,     6'd0, 7'd64, 1'b0}},
    '{1'b0, 1'b0, OP_SCAN_MASTER, 32'hFFFF_FFFF, 1'b1, '{STATUS_NOMATCH,   6'd0, 7'd64, 1'b0}},
    '{1'b0, 1'b0, OP_REMOVE,      32'hFFFF_FFFF, 1'b1, '{STATUS_NOTFOUND,  6'd0, 7'd64, 1'b0}},
    '{1'b0, 1'b0, OP_ADD,         32'hFFFF_FFFF, 1'b1, '{STATUS_ADDED,     6'd1, 7'd63, 1'b0}},
    '{1'b0, 1'b0, OP_ADD,         32'h0000_0000, 1'b1, '{STATUS_ADDED,     6'd2, 7'd62, 1'b0}},
    '{1'b0, 1'b0, OP_ADD,         32'hFFFF_FFFF, 1'b1, '{STATUS_DUPLICATE, 6'd0, 7'd62, 1'b0}},
    '{1'b0, 1'b0, OP_SCAN_ALL,    32'h0000_0000, 1'b1, '{STATUS_MATCH,     6'd2, 7'd62, 1'b0}},
    '{1'b0, 1'b0, OP_REMOVE,      32'hFFFF_FFFF, 1'b1, '{STATUS_REMOVED,   6'd1, 7'd63, 1'b0}},
    // the freed slot 1 is the lowest free one again
    '{1'b0, 1'b0, OP_ADD,         32'hA5A5_A5A5, 1'b1, '{STATUS_ADDED,     6'd1, 7'd62, 1'b0}},
    '{1'b0, 1'b0, OP_SCAN_ALL,    32'hFFFF_FFFF, 1'b1, '{STATUS_NOMATCH,   6'd0, 7'd62, 1'b0}},
    // enable the master with a wide write value, only bit zero counts
    '{1'b1, CFG_MASTER_UID, OP_SCAN_ALL, 32'h5A5A_5A5A, 1'b0, '0},
    '{1'b1, CFG_MASTER_EN,  OP_SCAN_ALL, 32'hFFFF_FFFF, 1'b0, '0},
    '{1'b0, 1'b0, OP_SCAN_ALL,    32'h5A5A_5A5A, 1'b1, '{STATUS_MATCH,     6'd0, 7'd61, 1'b1}},
    '{1'b0, 1'b0, OP_ADD,         32'h5A5A_5A5A, 1'b1, '{STATUS_DUPLICATE, 6'd0, 7'd61, 1'b1}},
    // the master slot can never be removed
    '{1'b0, 1'b0, OP_REMOVE,      32'h5A5A_5A5A, 1'b1, '{STATUS_NOTFOUND,  6'd0, 7'd61, 1'b1}},
    '{1'b0, 1'b0, OP_SCAN_MASTER, 32'h0000_0000, 1'b1, '{STATUS_NOMATCH,   6'd0, 7'd61, 1'b1}},
    // disable again with an even wide value
    '{1'b1, CFG_MASTER_EN,  OP_SCAN_ALL, 32'hFFFF_FFFE, 1'b0, '0},
    '{1'b0, 1'b0, OP_SCAN_MASTER, 32'h5A5A_5A5A, 1'b1, '{STATUS_MATCH,     6'd0, 7'd62, 1'b0}},
    '{1'b0, 1'b0, OP_SCAN_ALL,    32'h5A5A_5A5A, 1'b1, '{STATUS_NOMATCH,   6'd0, 7'd62, 1'b0}},
    // the master identifier also lands in a user slot; the master wins a scan
    '{1'b0, 1'b0, OP_ADD,         32'h5A5A_5A5A, 1'b0, '0},
    '{1'b1, CFG_MASTER_EN,  OP_SCAN_ALL, 32'h0000_0001, 1'b0, '0},
    '{1'b0, 1'b0, OP_SCAN_ALL,    32'h5A5A_5A5A, 1'b0, '0},
    '{1'b0, 1'b0, OP_REMOVE,      32'h5A5A_5A5A, 1'b0, '0},
    '{1'b0, 1'b0, OP_SCAN_ALL,    32'hA5A5_A5A5, 1'b0, '0}
  };

  card_id_whitelist_table_core #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_uid             (in_uid),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_slot_index     (out_slot_index),
    .out_free_slots     (out_free_slots),
    .out_master_present (out_master_present)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Lowest valid user slot holding id, counted from 1; zero when absent
  function automatic int find_card(logic [UID_W-1:0] id);
    int k;
    for (k = 0; k < USER_SLOTS; k++) begin
      if (card_valid[k] && card_ids[k] == id) return k + 1;
    end
    return 0;
  endfunction

  // Work out the result of one item and advance the table model
  function automatic verdict_t access_verdict(logic [OP_W-1:0] op, logic [UID_W-1:0] id);
    verdict_t v;
    int       hit;
    int       k;
    logic     master_hit;
    v          = '0;
    v.status   = STATUS_NOMATCH;
    master_hit = m_en && (m_uid == id);
    case (op)
      OP_SCAN_ALL: begin
        // the master is checked first and reports slot zero
        hit = master_hit ? 0 : find_card(id);
        if (master_hit || hit != 0) v.status = STATUS_MATCH;
        v.slot = SLOT_W_O'(hit);
      end
      OP_SCAN_MASTER: begin
        // compared whether or not the master is enabled
        if (m_uid == id) v.status = STATUS_MATCH;
      end
      OP_ADD: begin
        if (master_hit || find_card(id) != 0) begin
          v.status = STATUS_DUPLICATE;
        end else begin
          v.status = STATUS_FULL;
          for (k = 0; k < USER_SLOTS && v.status == STATUS_FULL; k++) begin
            if (!card_valid[k]) begin
              card_valid[k] = 1'b1;
              card_ids[k]   = id;
              free_cards--;
              v.status = STATUS_ADDED;
              v.slot   = SLOT_W_O'(k + 1);
            end
          end
        end
      end
      OP_REMOVE: begin
        hit = find_card(id);
        if (hit != 0) begin
          card_valid[hit-1] = 1'b0;
          free_cards++;
          v.status = STATUS_REMOVED;
          v.slot   = SLOT_W_O'(hit);
        end else begin
          v.status = STATUS_NOTFOUND;
        end
      end
      default: ;
    endcase
    v.free   = FREE_W_O'(free_cards + (m_en ? 0 : 1));
    v.master = m_en;
    return v;
  endfunction

  // Pick an identifier: a stored one at the given percentage, else sometimes the
  // master, a corner value or fresh random bits
  function automatic logic [UID_W-1:0] pick_card_id(int stored_pct);
    logic [UID_W-1:0] id;
    int               roll;
    int               k;
    int               tries;
    logic             found;
    id    = $urandom;
    roll  = $urandom_range(0, 99);
    found = 1'b0;
    if (roll < stored_pct) begin
      for (tries = 0; tries < 8 && !found; tries++) begin
        k = $urandom_range(0, USER_SLOTS - 1);
        if (card_valid[k]) begin
          id    = card_ids[k];
          found = 1'b1;
        end
      end
    end else if (roll < stored_pct + 10) begin
      id = m_uid;
    end else if (roll < stored_pct + 16) begin
      case ($urandom_range(0, 2))
        0:       id = '0;
        1:       id = '1;
        default: id = UID_W'(1) << $urandom_range(0, UID_W - 1);
      endcase
    end
    return id;
  endfunction

  function automatic logic [OP_W-1:0] choose_op(mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      FILL_ONLY:   return OP_ADD;
      FILL_HEAVY:  return roll < 75 ? OP_ADD : roll < 87 ? OP_SCAN_ALL :
                          roll < 94 ? OP_SCAN_MASTER : OP_REMOVE;
      DRAIN_HEAVY: return roll < 65 ? OP_REMOVE : roll < 85 ? OP_SCAN_ALL :
                          roll < 93 ? OP_ADD : OP_SCAN_MASTER;
      default:     return OP_W'(roll % 4);
    endcase
  endfunction

  task automatic report_mismatch(string text);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, text);
  endtask

  // Offer one item after a random idle gap; return at the edge that takes it.
  // Valid stays high on return so back-to-back items need no second assignment.
  task automatic offer_item(logic [OP_W-1:0] op, logic [UID_W-1:0] id,
                            logic typed, verdict_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_op     <= op;
    in_uid    <= id;
    row_typed <= typed;
    row_want  <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every outstanding result has been taken; step
  // one edge first so the item taken at this edge is already queued
  task automatic settle_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register writes only ever happen with the block idle
  task automatic write_register(logic sel, logic [UID_W-1:0] value);
    settle_all();
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_MASTER_UID) m_uid = value;
    else m_en = value[0];
  endtask

  // Predict at the edge that accepts an item; typed rows still advance the
  // model but queue the hand-written result instead
  always @(posedge clk) begin
    verdict_t predicted;
    if (rst_n && in_valid && !in_stall) begin
      predicted = access_verdict(in_op, in_uid);
      pending_verdicts.push_back(row_typed ? row_want : predicted);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected result: status %0d slot %0d",
                                  out_status, out_slot_index));
      end else begin
        want = pending_verdicts.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_slot_index !== want.slot)
          report_mismatch($sformatf("slot_index %0d, want %0d", out_slot_index, want.slot));
        if (out_free_slots !== want.free)
          report_mismatch($sformatf("free_slots %0d, want %0d", out_free_slots, want.free));
        if (out_master_present !== want.master)
          report_mismatch($sformatf("master_present %0b, want %0b",
                                    out_master_present, want.master));
      end
    end
  end

  // Result side: random stalls, or a long hold-off when the stimulus asks
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left  <= LONG_HOLD;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Give up when neither channel has moved for far longer than a correct
  // block ever needs (clearing pass, long hold-off and a full walk included)
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int        n;
    int        phase;
    int        left;
    int        run;
    mix_t      mix;
    plan_row_t row;
    logic [OP_W-1:0] op;

    m_uid      = '0;
    m_en       = 1'b0;
    free_cards = USER_SLOTS;
    for (n = 0; n < USER_SLOTS; n++) begin
      card_ids[n]   = '0;
      card_valid[n] = 1'b0;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows, no idling on either side
    for (n = 0; n < DIRECTED_ROWS; n++) begin
      row = directed_plan[n];
      if (row.is_cfg) write_register(row.reg_sel, row.value);
      else offer_item(row.op, row.value, row.typed, row.want);
    end

    // Random traffic in idling phases, with a fresh master setting each time
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          write_register(CFG_MASTER_UID, $urandom);
          write_register(CFG_MASTER_EN, 32'h1);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          // hold the result side off while items keep coming, so the
          // block fills up and stalls its input
          hold_asked <= hold_asked + 1;
        end
        1: begin
          write_register(CFG_MASTER_UID, 32'hFFFF_FFFF);
          write_register(CFG_MASTER_EN, 32'h0);
          send_idle_pct  = 58;
          recv_stall_pct = 0;
        end
        2: begin
          write_register(CFG_MASTER_UID, 32'h0);
          write_register(CFG_MASTER_EN, 32'h1);
          send_idle_pct  = 0;
          recv_stall_pct = 58;
        end
        default: begin
          write_register(CFG_MASTER_UID, $urandom);
          write_register(CFG_MASTER_EN, $urandom);
          send_idle_pct  = 13;
          recv_stall_pct = 13;
        end
      endcase

      // open the first phase with a run of pure adds to fill the table
      mix  = FILL_ONLY;
      run  = (phase == 0) ? USER_SLOTS + 3 : 0;
      left = RANDOM_ITEMS / PHASES;
      while (left > 0) begin
        if (run == 0) begin
          mix = mix_t'($urandom_range(FILL_HEAVY, EVEN_MIX));
          run = $urandom_range(10, 90);
        end
        op = choose_op(mix);
        offer_item(op, pick_card_id(op == OP_ADD ? 20 : 60), 1'b0, '0);
        run--;
        left--;
        // pause the sender once until the pipeline has emptied
        if (phase == 1 && left == RANDOM_ITEMS / PHASES / 2) settle_all();
      end
    end

    settle_all();
    repeat (SLOTS + 6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
